// ===== rtl/klc_pkg.sv =====
package klc_pkg;

    localparam int MAX_KEYS = 16;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int TIME_W   = 17;
    localparam int VAL_W    = 32;
    localparam int KEY_W    = TIME_W + 2 * VAL_W;

    localparam logic [TIME_W-1:0] TIME_ONE = 17'd65536;
    localparam logic [VAL_W-1:0]  VAL_ONE  = 32'sd65536;
    localparam logic [VAL_W-1:0]  VAL_MONE = -32'sd65536;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_EVAL   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_RESET  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_INDEX = 2'd3;

    typedef struct packed {
        logic          start;
        logic [63:0]   dividend;
        logic [17:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [63:0]   quotient;
    } div_rsp_t;

endpackage

// ===== rtl/klc_div.sv =====
module klc_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  klc_pkg::div_req_t req,
    output klc_pkg::div_rsp_t rsp
);

    logic [63:0] quot_reg, quot_next;
    logic [17:0] rem_reg, rem_next;
    logic [17:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        neg_reg, neg_next;
    logic [18:0] trial;
    logic [63:0] mag;

    always_comb
    begin
        mag        = req.dividend[63] ? (~req.dividend + 64'd1) : req.dividend;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, quot_reg[63]} - {1'b0, dvs_reg};
        if (req.start)
        begin
            quot_next = mag;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
            neg_next  = req.dividend[63];
        end
        else if (busy_reg)
        begin
            if (!trial[18])
            begin
                rem_next  = trial[17:0];
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[16:0], quot_reg[63]};
                quot_next = {quot_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~quot_reg + 64'd1) : quot_reg;

endmodule

// ===== rtl/keyframe_linear_curve.sv =====
// Keyframe curve: a table of up to MAX_KEYS keys in flip-flops, sorted by
// time. One transaction at a time: a command walks the table one key per
// cycle (search, then shift for insert/remove), and an interpolating
// evaluate adds a multiply state, a divider start state and a 64-step
// serial divide. The block returns to idle after each transaction before
// the next is accepted. in_stall is high while a command is in progress or
// its result waits in the output register.
module keyframe_linear_curve
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [16:0] key_time,
    input  logic [31:0] left_value,
    input  logic [31:0] right_value,
    input  logic [3:0]  key_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] curve_value,
    output logic [1:0]  status,
    output logic [4:0]  key_count
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRCH  = 7'b0000010,
        S_SHIFT = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    localparam int IW = klc_pkg::IDX_W;
    localparam int CW = klc_pkg::CNT_W;

    state_t state_reg, state_next;
    logic [16:0] tm_reg [klc_pkg::MAX_KEYS];
    logic [31:0] lv_reg [klc_pkg::MAX_KEYS];
    logic [31:0] rv_reg [klc_pkg::MAX_KEYS];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] k_reg, k_next;
    logic [1:0]  cmd_reg;
    logic [16:0] t_reg;
    logic [31:0] l_reg, r_reg;
    logic [CW-1:0] idx_reg;
    logic [31:0] val_reg, val_next;
    logic [1:0]  st_reg, st_next;
    logic [63:0] prod_reg;
    logic [17:0] span_reg;
    logic [31:0] base_reg;
    logic        wr_en, wr_shift_up, wr_shift_dn, wr_reset;
    logic [IW-1:0] k_ix, km1_ix;
    logic signed [32:0] diff_w;
    logic [16:0] dt_w;
    logic signed [50:0] mul_w;
    klc_pkg::div_req_t dreq;
    klc_pkg::div_rsp_t drsp;

    assign k_ix   = k_reg[IW-1:0];
    assign km1_ix = k_ix - IW'(1);

    assign diff_w = $signed({lv_reg[k_ix][31], lv_reg[k_ix]})
                  - $signed({rv_reg[km1_ix][31], rv_reg[km1_ix]});
    assign dt_w   = t_reg - tm_reg[km1_ix];
    assign mul_w  = diff_w * $signed({1'b0, dt_w});

    klc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        val_next    = val_reg;
        st_next     = st_reg;
        wr_en       = 1'b0;
        wr_shift_up = 1'b0;
        wr_shift_dn = 1'b0;
        wr_reset    = 1'b0;
        dreq.start    = 1'b0;
        dreq.dividend = prod_reg;
        dreq.divisor  = span_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next   = '0;
                    st_next    = klc_pkg::ST_OK;
                    k_next     = '0;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (cmd_reg == klc_pkg::CMD_RESET)
                begin
                    wr_reset   = 1'b1;
                    cnt_next   = CW'(2);
                    state_next = S_OUT;
                end
                else if (cmd_reg == klc_pkg::CMD_REMOVE)
                begin
                    if (idx_reg >= cnt_reg)
                    begin
                        st_next    = klc_pkg::ST_INDEX;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        k_next     = idx_reg;
                        state_next = S_SHIFT;
                    end
                end
                else if (t_reg > klc_pkg::TIME_ONE)
                begin
                    st_next    = klc_pkg::ST_RANGE;
                    val_next   = klc_pkg::VAL_MONE;
                    state_next = S_OUT;
                end
                else if (cmd_reg == klc_pkg::CMD_EVAL && cnt_reg == '0)
                begin
                    st_next    = klc_pkg::ST_INDEX;
                    state_next = S_OUT;
                end
                else if (cmd_reg == klc_pkg::CMD_EVAL && t_reg == '0)
                begin
                    val_next   = rv_reg[0];
                    state_next = S_OUT;
                end
                else if (k_reg < cnt_reg && tm_reg[k_ix] < t_reg)
                begin
                    k_next = k_reg + CW'(1);
                end
                else if (cmd_reg == klc_pkg::CMD_EVAL)
                begin
                    if (k_reg == '0)
                    begin
                        val_next   = lv_reg[0];
                        state_next = S_OUT;
                    end
                    else if (k_reg >= cnt_reg)
                    begin
                        val_next   = rv_reg[km1_ix];
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
                else if (k_reg < cnt_reg && tm_reg[k_ix] == t_reg)
                begin
                    wr_en      = 1'b1;
                    state_next = S_OUT;
                end
                else if (cnt_reg >= CW'(klc_pkg::MAX_KEYS))
                begin
                    st_next    = klc_pkg::ST_FULL;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (cmd_reg == klc_pkg::CMD_REMOVE)
                begin
                    if (k_reg + CW'(1) < cnt_reg)
                    begin
                        wr_shift_dn = 1'b1;
                        k_next      = k_reg + CW'(1);
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    wr_shift_up = 1'b1;
                    if (idx_reg == k_reg)
                    begin
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = S_OUT;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                dreq.start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (drsp.done)
                begin
                    val_next   = base_reg + drsp.quotient[31:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // shift-up walks a pointer (idx_reg) down from count to the slot
    logic [IW-1:0] p_ix, pm1_ix;
    assign p_ix   = idx_reg[IW-1:0];
    assign pm1_ix = p_ix - IW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= CW'(2);
            for (int i = 0; i < klc_pkg::MAX_KEYS; i++)
            begin
                tm_reg[i] <= (i == 1) ? klc_pkg::TIME_ONE : '0;
                lv_reg[i] <= (i == 1) ? klc_pkg::VAL_ONE : '0;
                rv_reg[i] <= (i == 1) ? klc_pkg::VAL_ONE : '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (wr_reset)
            begin
                for (int i = 0; i < klc_pkg::MAX_KEYS; i++)
                begin
                    tm_reg[i] <= (i == 1) ? klc_pkg::TIME_ONE : '0;
                    lv_reg[i] <= (i == 1) ? klc_pkg::VAL_ONE : '0;
                    rv_reg[i] <= (i == 1) ? klc_pkg::VAL_ONE : '0;
                end
            end
            if (wr_en)
            begin
                lv_reg[k_ix] <= l_reg;
                rv_reg[k_ix] <= r_reg;
            end
            if (wr_shift_dn)
            begin
                tm_reg[k_ix] <= tm_reg[k_ix + IW'(1)];
                lv_reg[k_ix] <= lv_reg[k_ix + IW'(1)];
                rv_reg[k_ix] <= rv_reg[k_ix + IW'(1)];
            end
            if (wr_shift_up)
            begin
                if (idx_reg == k_reg)
                begin
                    tm_reg[p_ix] <= t_reg;
                    lv_reg[p_ix] <= l_reg;
                    rv_reg[p_ix] <= r_reg;
                end
                else
                begin
                    tm_reg[p_ix] <= tm_reg[pm1_ix];
                    lv_reg[p_ix] <= lv_reg[pm1_ix];
                    rv_reg[p_ix] <= rv_reg[pm1_ix];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        val_reg <= val_next;
        st_reg  <= st_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            cmd_reg <= command;
            t_reg   <= key_time;
            l_reg   <= left_value;
            r_reg   <= right_value;
            idx_reg <= CW'(key_index);
        end
        else if (state_reg == S_SRCH && state_next == S_SHIFT
                 && cmd_reg == klc_pkg::CMD_INSERT)
        begin
            idx_reg <= cnt_reg;
        end
        else if (wr_shift_up && idx_reg != k_reg)
        begin
            idx_reg <= idx_reg - CW'(1);
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= {{13{mul_w[50]}}, mul_w};
            span_reg <= {1'b0, tm_reg[k_ix] - tm_reg[km1_ix]};
            base_reg <= rv_reg[km1_ix];
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign curve_value = val_reg;
    assign status      = st_reg;
    assign key_count   = 5'(cnt_reg);

endmodule

// ===== rtl/klc_checker.sv =====
module klc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [4:0]  key_count,
    input logic [31:0] curve_value
);

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_count <= 5'd16)
        else $error("key count above table size");

    a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(curve_value))
        else $error("result dropped under stall");

    a_range_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == klc_pkg::ST_RANGE |-> curve_value == klc_pkg::VAL_MONE)
        else $error("range error value wrong");

endmodule

bind keyframe_linear_curve klc_checker u_klc_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .key_count(key_count), .curve_value(curve_value)
);

// ===== verif/keyframe_checker.sv =====
`timescale 1ns / 1ps

module keyframe_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  command,
    input  logic [16:0] key_time,
    input  logic [31:0] left_value,
    input  logic [31:0] right_value,
    input  logic [3:0]  key_index,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] curve_value,
    input  logic [1:0]  status,
    input  logic [4:0]  key_count,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  st;
        logic [4:0]  cnt;
    } curve_result_t;

    logic [16:0]        times_m  [klc_pkg::MAX_KEYS];
    logic signed [31:0] lefts_m  [klc_pkg::MAX_KEYS];
    logic signed [31:0] rights_m [klc_pkg::MAX_KEYS];
    int                 held;
    curve_result_t      expected_q[$];

    function automatic void load_endpoints();
        for (int k = 0; k < klc_pkg::MAX_KEYS; k++)
        begin
            times_m[k]  = '0;
            lefts_m[k]  = '0;
            rights_m[k] = '0;
        end
        times_m[1]  = klc_pkg::TIME_ONE;
        lefts_m[1]  = 32'sd65536;
        rights_m[1] = 32'sd65536;
        held = 2;
    endfunction

    function automatic int slot_of(logic [16:0] t);
        int k;
        k = 0;
        while (k < held && times_m[k] < t)
            k++;
        return k;
    endfunction

    function automatic logic [31:0] curve_at(logic [16:0] t);
        int nx;
        int pv;
        longint span;
        longint num;
        if (t == 0)
            return rights_m[0];
        nx = slot_of(t);
        if (nx == 0)
            return lefts_m[0];
        if (nx >= held)
            return rights_m[held - 1];
        pv = nx - 1;
        span = longint'(times_m[nx]) - longint'(times_m[pv]);
        num = (longint'(lefts_m[nx]) - longint'(rights_m[pv]))
            * (longint'(t) - longint'(times_m[pv]));
        return 32'(longint'(rights_m[pv]) + num / span);
    endfunction

    function automatic curve_result_t apply_command(logic [1:0] cmd, logic [16:0] t,
            logic [31:0] lv, logic [31:0] rv, logic [3:0] idx);
        curve_result_t r;
        int pos;
        r = '0;
        case (cmd)
            klc_pkg::CMD_INSERT:
            begin
                if (t > klc_pkg::TIME_ONE)
                begin
                    r.st = klc_pkg::ST_RANGE;
                    r.value = klc_pkg::VAL_MONE;
                end
                else
                begin
                    pos = slot_of(t);
                    if (pos < held && times_m[pos] == t)
                    begin
                        lefts_m[pos] = lv;
                        rights_m[pos] = rv;
                    end
                    else if (held >= klc_pkg::MAX_KEYS)
                        r.st = klc_pkg::ST_FULL;
                    else
                    begin
                        for (int k = held; k > pos; k--)
                        begin
                            times_m[k]  = times_m[k-1];
                            lefts_m[k]  = lefts_m[k-1];
                            rights_m[k] = rights_m[k-1];
                        end
                        times_m[pos] = t;
                        lefts_m[pos] = lv;
                        rights_m[pos] = rv;
                        held++;
                    end
                end
            end
            klc_pkg::CMD_EVAL:
            begin
                if (t > klc_pkg::TIME_ONE)
                begin
                    r.st = klc_pkg::ST_RANGE;
                    r.value = klc_pkg::VAL_MONE;
                end
                else if (held == 0)
                    r.st = klc_pkg::ST_INDEX;
                else
                    r.value = curve_at(t);
            end
            klc_pkg::CMD_REMOVE:
            begin
                if (idx >= held)
                    r.st = klc_pkg::ST_INDEX;
                else
                begin
                    for (int k = idx; k + 1 < held; k++)
                    begin
                        times_m[k]  = times_m[k+1];
                        lefts_m[k]  = lefts_m[k+1];
                        rights_m[k] = rights_m[k+1];
                    end
                    held--;
                end
            end
            default: load_endpoints();
        endcase
        r.cnt = 5'(held);
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        curve_result_t exp_r;
        curve_result_t pred_r;
        if (!rst_n)
        begin
            load_endpoints();
            expected_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pred_r = apply_command(command, key_time, left_value,
                                       right_value, key_index);
                expected_q.insert(expected_q.size(), pred_r);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result value=%h status=%0d count=%0d",
                                 curve_value, status, key_count);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.value !== curve_value || exp_r.st !== status
                        || exp_r.cnt !== key_count)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: expected value=%h status=%0d count=%0d, got value=%h status=%0d count=%0d",
                                     exp_r.value, exp_r.st, exp_r.cnt,
                                     curve_value, status, key_count);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [16:0] key_time;
    logic [31:0] left_value;
    logic [31:0] right_value;
    logic [3:0]  key_index;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] curve_value;
    logic [1:0]  status;
    logic [4:0]  key_count;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;

    keyframe_linear_curve dut (.*);

    keyframe_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_command(logic [1:0] cmd, logic [16:0] t, logic [31:0] lv,
                                logic [31:0] rv, logic [3:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        key_time    <= t;
        left_value  <= lv;
        right_value <= rv;
        key_index   <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [16:0] rand_time();
        case ($urandom_range(9))
            0: return 17'($urandom_range(131071));
            1: return klc_pkg::TIME_ONE;
            2: return 17'd0;
            3: return 17'($urandom_range(65536) & 17'h1F000);
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        if ($urandom_range(3) == 0)
            return $urandom();
        return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
    endfunction

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            send_command(klc_pkg::CMD_INSERT, rand_time(), rand_value(), rand_value(),
                         4'($urandom));
        else if (pick < 80)
            send_command(klc_pkg::CMD_EVAL, rand_time(), rand_value(), rand_value(),
                         4'($urandom));
        else if (pick < 97)
            send_command(klc_pkg::CMD_REMOVE, rand_time(), rand_value(), rand_value(),
                         4'($urandom_range(15)));
        else
            send_command(klc_pkg::CMD_RESET, 17'($urandom), $urandom(), $urandom(),
                         4'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = klc_pkg::CMD_RESET;
        key_time = '0;
        left_value = '0;
        right_value = '0;
        key_index = '0;
        out_stall = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 51;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_command(klc_pkg::CMD_EVAL, 17'd0, '0, '0, '0);
        send_command(klc_pkg::CMD_EVAL, 17'd32768, '0, '0, '0);
        send_command(klc_pkg::CMD_EVAL, klc_pkg::TIME_ONE, '0, '0, '0);
        send_command(klc_pkg::CMD_EVAL, 17'h1FFFF, '0, '0, '0);
        send_command(klc_pkg::CMD_INSERT, 17'd65537, 32'h1, 32'h2, '0);
        send_command(klc_pkg::CMD_INSERT, 17'd16384, 32'h80000000, 32'h7FFFFFFF, '0);
        send_command(klc_pkg::CMD_INSERT, 17'd16384, 32'hFFFFFFFF, 32'h80000000, '0);
        send_command(klc_pkg::CMD_EVAL, 17'd8192, '0, '0, '0);
        send_command(klc_pkg::CMD_EVAL, 17'd40000, '0, '0, '0);
        send_command(klc_pkg::CMD_INSERT, 17'd0, 32'h12345678, 32'h7FFFFFFF, '0);
        send_command(klc_pkg::CMD_REMOVE, '0, '0, '0, 4'd15);
        send_command(klc_pkg::CMD_REMOVE, '0, '0, '0, 4'd0);
        send_command(klc_pkg::CMD_EVAL, 17'd0, '0, '0, '0);
        send_command(klc_pkg::CMD_REMOVE, '0, '0, '0, 4'd2);
        send_command(klc_pkg::CMD_REMOVE, '0, '0, '0, 4'd0);
        send_command(klc_pkg::CMD_REMOVE, '0, '0, '0, 4'd0);
        send_command(klc_pkg::CMD_EVAL, 17'd100, '0, '0, '0);
        send_command(klc_pkg::CMD_REMOVE, '0, '0, '0, 4'd0);
        send_command(klc_pkg::CMD_INSERT, 17'd50000, 32'h00020000, 32'hFFFE0000, '0);
        send_command(klc_pkg::CMD_EVAL, 17'd1000, '0, '0, '0);
        send_command(klc_pkg::CMD_EVAL, 17'd60000, '0, '0, '0);
        for (int k = 0; k < 16; k++)
            send_command(klc_pkg::CMD_INSERT, 17'(k * 4000 + 7), rand_value(),
                         rand_value(), '0);
        send_command(klc_pkg::CMD_INSERT, 17'd65000, '0, '0, '0);
        send_command(klc_pkg::CMD_EVAL, 17'd9000, '0, '0, '0);
        send_command(klc_pkg::CMD_RESET, 17'h1FFFF, '1, '1, '1);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 10 : 0;
            for (int n = 0; n < 580; n++)
                random_item();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== keyframe_linear_curve.f =====
rtl/klc_pkg.sv
rtl/klc_div.sv
rtl/keyframe_linear_curve.sv
rtl/klc_checker.sv
verif/keyframe_checker.sv
verif/testbench.sv
